[src/sfd_pkg.sv]
// sfd_pkg: shared widths, reset values, tanh knot table and stage-enable type
// for the stereo feedback delay. Used by sfd_regs, sfd_chan and the top level.
package sfd_pkg;

  localparam int GAIN_W  = 16;
  localparam int DELAY_W = 15;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd29491;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 15'd24000;

  localparam int KNOTS = 17;

  // tanh(k/8), k = 0..16, in Q1.15
  localparam logic [15:0] TANH_KNOTS [KNOTS] = '{
    16'd0,     16'd4075,  16'd8025,  16'd11743, 16'd15143, 16'd18173,
    16'd20813, 16'd23071, 16'd24956, 16'd26519, 16'd27797, 16'd28832,
    16'd29660, 16'd30322, 16'd30847, 16'd31262, 16'd31589
  };

  // Knot rescaled from Q1.15 to a sample of sw bits (sw-1 fraction bits), truncating.
  function automatic logic [31:0] knot_scaled(input logic [4:0] k, input int sw);
    logic [47:0] t;
    t = 48'(TANH_KNOTS[k]) << (sw - 1);
    return 32'(t >> 15);
  endfunction

  typedef struct packed {
    logic ld1;     // accept into stage 1
    logic ld2;     // stage 1 -> stage 2
    logic ld3;     // stage 2 -> stage 3
    logic ld_out;  // stage 3 -> result register, store write
  } stage_en_t;

endpackage

[src/sfd_regs.sv]
// sfd_regs: APB register file for feedback gain and delay. Also keeps the delay
// reduced modulo the store depth. Depends on sfd_pkg.
module sfd_regs #(
  parameter int STORE_DEPTH = 32768
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfd_pkg::PADDR_W-1:0]         paddr,
  input  logic [sfd_pkg::PDATA_W-1:0]         pwdata,
  output logic [sfd_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  output logic [sfd_pkg::GAIN_W-1:0]          gain,
  output logic [$clog2(STORE_DEPTH)-1:0]      delay_mod
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SH = sfd_pkg::DELAY_W + AW;
  // reciprocal of the depth: floor(d*RECIP >> SH) == d / STORE_DEPTH for any 15-bit d
  localparam longint RECIP = ((longint'(1) << SH) + longint'(STORE_DEPTH) - 1)
                             / longint'(STORE_DEPTH);
  localparam longint DELAY_MOD_RESET = longint'(sfd_pkg::DELAY_RESET) % longint'(STORE_DEPTH);

  typedef enum logic {
    REG_FEEDBACK_GAIN = 1'b0,
    REG_DELAY_SAMPLES = 1'b1
  } reg_idx_t;

  reg_idx_t                     idx;
  logic                         wr_access;
  logic                         wr_setup;
  logic [sfd_pkg::DELAY_W-1:0]  delay_samples;
  logic [sfd_pkg::DELAY_W-1:0]  wdelay;
  logic [47:0]                  recip_prod;
  logic [sfd_pkg::DELAY_W-1:0]  quot;
  logic [31:0]                  quot_times_depth;
  logic [31:0]                  mod_full;

  assign pready    = 1'b1;
  assign idx       = reg_idx_t'(paddr[2]);
  assign wr_access = psel && penable && pwrite && pready;
  assign wr_setup  = psel && !penable && pwrite && (idx == REG_DELAY_SAMPLES);
  assign wdelay    = pwdata[sfd_pkg::DELAY_W-1:0];

  // quotient is formed in the setup phase, the remainder in the access phase
  assign recip_prod       = 48'(wdelay) * 48'(RECIP);
  assign quot_times_depth = 32'(quot) * 32'(STORE_DEPTH);
  assign mod_full         = 32'(wdelay) - quot_times_depth;

  always_ff @(posedge clk) begin
    if (wr_setup) begin
      quot <= sfd_pkg::DELAY_W'(recip_prod >> SH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= sfd_pkg::GAIN_RESET;
      delay_samples <= sfd_pkg::DELAY_RESET;
      delay_mod     <= AW'(DELAY_MOD_RESET);
    end else if (wr_access) begin
      unique case (idx)
        REG_FEEDBACK_GAIN: gain <= pwdata[sfd_pkg::GAIN_W-1:0];
        REG_DELAY_SAMPLES: begin
          delay_samples <= wdelay;
          delay_mod     <= mod_full[AW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FEEDBACK_GAIN: prdata = sfd_pkg::PDATA_W'(gain);
      REG_DELAY_SAMPLES: prdata = sfd_pkg::PDATA_W'(delay_samples);
      default:           prdata = '0;
    endcase
  end

endmodule

[src/sfd_echo_mem.sv]
// sfd_echo_mem: circular echo store for one channel, one write and one
// registered read port. No dependencies.
module sfd_echo_mem #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/sfd_chan.sv]
// sfd_chan: per-channel datapath: feedback multiply, tanh soft clip by knot
// interpolation, dry+half-echo result register. Depends on sfd_pkg.
module sfd_chan #(
  parameter int SW = 16
) (
  input  logic                        clk,
  input  sfd_pkg::stage_en_t          en,
  input  logic [sfd_pkg::GAIN_W-1:0]  gain,
  input  logic                        hit,
  input  logic signed [SW-1:0]        sample_in,
  input  logic signed [SW-1:0]        rdata,
  output logic signed [SW-1:0]        wdata,
  output logic signed [SW:0]          result
);

  localparam int RW  = SW + 1;
  localparam int PW  = SW + sfd_pkg::GAIN_W + 1;
  localparam int XW  = SW + 2;
  localparam int SEG = SW - 4;
  localparam int DW  = SW - 3;
  localparam int IPW = DW + SEG;

  // stage 1
  logic signed [SW-1:0]  in1;
  logic signed [SW-1:0]  delayed;
  logic signed [PW-1:0]  prod1;
  logic signed [RW-1:0]  res1;
  // stage 2
  logic signed [SW-1:0]  in2;
  logic signed [PW-1:0]  prod2;
  logic signed [RW-1:0]  res2;
  logic signed [PW-1:0]  prod_rnd;
  logic signed [RW-1:0]  fb;
  logic signed [XW-1:0]  x;
  logic [XW-1:0]         mag;
  logic [SW-1:0]         a;
  logic [3:0]            seg;
  logic [SEG-1:0]        frac;
  logic [31:0]           k0_w;
  logic [31:0]           k1_w;
  logic [SW-2:0]         y0;
  logic [SW-2:0]         y1;
  logic [DW-1:0]         diff;
  logic [IPW-1:0]        ip;
  // stage 3
  logic [IPW-1:0]        ip3;
  logic [SW-2:0]         y0_3;
  logic                  neg3;
  logic signed [RW-1:0]  res3;
  logic [IPW-1:0]        ip_rnd;
  logic [SW-2:0]         y;

  // never-written entries read as zero
  assign delayed = hit ? rdata : '0;
  assign prod1   = delayed * $signed({1'b0, gain});
  assign res1    = RW'(in1) + RW'(delayed >>> 1);

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      in1 <= sample_in;
    end
    if (en.ld2) begin
      in2   <= in1;
      prod2 <= prod1;
      res2  <= res1;
    end
    if (en.ld3) begin
      ip3  <= ip;
      y0_3 <= y0;
      neg3 <= x[XW-1];
      res3 <= res2;
    end
    if (en.ld_out) begin
      result <= res3;
    end
  end

  // feedback term, rounded to nearest with ties up
  assign prod_rnd = prod2 + PW'(32768);
  assign fb       = $signed(prod_rnd[PW-1:16]);
  assign x        = XW'(in2) + XW'(fb);
  assign mag      = x[XW-1] ? (~x + XW'(1)) : x;
  // clamp just under 2.0
  assign a        = (mag[XW-1:SW] != '0) ? {SW{1'b1}} : mag[SW-1:0];
  assign seg      = a[SW-1:SEG];
  assign frac     = a[SEG-1:0];
  assign k0_w     = sfd_pkg::knot_scaled({1'b0, seg}, SW);
  assign k1_w     = sfd_pkg::knot_scaled({1'b0, seg} + 5'd1, SW);
  assign y0       = k0_w[SW-2:0];
  assign y1       = k1_w[SW-2:0];
  assign diff     = DW'(y1 - y0);
  assign ip       = IPW'(diff) * IPW'(frac);

  assign ip_rnd = ip3 + IPW'(1 << (SEG - 1));
  assign y      = y0_3 + (SW-1)'(ip_rnd[IPW-1:SEG]);
  assign wdata  = neg3 ? -$signed({1'b0, y}) : $signed({1'b0, y});

endmodule

[src/stereo_feedback_delay_softclip.sv]
// stereo_feedback_delay_softclip: top level of the stereo feedback echo with
// tanh soft clip. Depends on sfd_pkg, sfd_regs, sfd_echo_mem, sfd_chan.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   input    | in_valid / in_stall        | left_sample, right_sample
//   result   | out_valid / out_stall      | left_result, right_result
//   config   | APB psel/penable/pready    | paddr, pwdata, prdata
//
// One item per cycle while no result stall or store hazard holds input; an accepted
// item goes through the store read at acceptance, then feedback multiply, clip
// interpolation and the result register.
// An item whose read position is still being written by one of the three items
// in flight waits for that write, so a delay_samples mod STORE_DEPTH of 1..3
// lowers the input rate.
// Reset clears control only; unwritten store entries are tracked by the write
// position and a wrap flag and read as zero. Result stalls back up through the
// stage registers; bubbles close up, so input is taken while a result waits.
module stereo_feedback_delay_softclip #(
  parameter int STORE_DEPTH  = 32768,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_WIDTH:0]  left_result,
  output logic signed [SAMPLE_WIDTH:0]  right_result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfd_pkg::PADDR_W-1:0]   paddr,
  input  logic [sfd_pkg::PDATA_W-1:0]   pwdata,
  output logic [sfd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SW = SAMPLE_WIDTH;

  logic [sfd_pkg::GAIN_W-1:0] gain;
  logic [AW-1:0]              delay_mod;

  logic                       s1_valid;
  logic                       s2_valid;
  logic                       s3_valid;
  logic [AW-1:0]              wp;
  logic [AW-1:0]              wp1;
  logic [AW-1:0]              wp2;
  logic [AW-1:0]              wp3;
  logic                       wrapped;
  logic                       hit1;
  logic                       wp_last;
  logic [AW:0]                rd_diff;
  logic [AW-1:0]              rd_addr;
  logic                       rd_hit;
  logic                       hazard;
  logic                       out_free;
  logic                       s3_free;
  logic                       s2_free;
  logic                       s1_free;
  logic                       accept;
  sfd_pkg::stage_en_t         en;

  logic signed [SW-1:0]       left_rdata;
  logic signed [SW-1:0]       right_rdata;
  logic signed [SW-1:0]       left_wdata;
  logic signed [SW-1:0]       right_wdata;

  sfd_regs #(.STORE_DEPTH(STORE_DEPTH)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .gain      (gain),
    .delay_mod (delay_mod)
  );

  // read position, wrapped into the store
  assign rd_diff = {1'b0, wp} - {1'b0, delay_mod};
  assign rd_addr = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(STORE_DEPTH)) : rd_diff[AW-1:0];
  assign rd_hit  = wrapped || (rd_addr < wp);
  assign wp_last = (wp == AW'(STORE_DEPTH - 1));

  // read would miss a write still in the pipeline
  assign hazard = (s1_valid && (wp1 == rd_addr)) ||
                  (s2_valid && (wp2 == rd_addr)) ||
                  (s3_valid && (wp3 == rd_addr));

  assign out_free = !out_valid || !out_stall;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_stall = !s1_free || hazard;
  assign accept   = in_valid && !in_stall;

  assign en.ld1    = accept;
  assign en.ld2    = s1_valid && s2_free;
  assign en.ld3    = s2_valid && s3_free;
  assign en.ld_out = s3_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      wp        <= '0;
      wrapped   <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= accept;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
      if (out_free) out_valid <= s3_valid;
      if (accept) begin
        wp      <= wp_last ? '0 : wp + AW'(1);
        wrapped <= wrapped || wp_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      wp1  <= wp;
      hit1 <= rd_hit;
    end
    if (en.ld2) wp2 <= wp1;
    if (en.ld3) wp3 <= wp2;
  end

  sfd_echo_mem #(.DEPTH(STORE_DEPTH), .WIDTH(SW)) u_left_mem (
    .clk   (clk),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (left_rdata),
    .we    (en.ld_out),
    .waddr (wp3),
    .wdata (left_wdata)
  );

  sfd_echo_mem #(.DEPTH(STORE_DEPTH), .WIDTH(SW)) u_right_mem (
    .clk   (clk),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (right_rdata),
    .we    (en.ld_out),
    .waddr (wp3),
    .wdata (right_wdata)
  );

  sfd_chan #(.SW(SW)) u_left (
    .clk       (clk),
    .en        (en),
    .gain      (gain),
    .hit       (hit1),
    .sample_in (left_sample),
    .rdata     (left_rdata),
    .wdata     (left_wdata),
    .result    (left_result)
  );

  sfd_chan #(.SW(SW)) u_right (
    .clk       (clk),
    .en        (en),
    .gain      (gain),
    .hit       (hit1),
    .sample_in (right_sample),
    .rdata     (right_rdata),
    .wdata     (right_wdata),
    .result    (right_result)
  );

`ifndef SYNTH
  // stages 1 and 2 hold consecutive write positions
  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid) |->
      (((wp2 == AW'(STORE_DEPTH - 1)) && (wp1 == '0)) ||
       ((wp2 != AW'(STORE_DEPTH - 1)) && (wp1 == wp2 + AW'(1)))))
    else $error("stage write positions out of order");

  // a blocked last stage keeps its item
  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !out_free) |=> (s3_valid && $stable(wp3)))
    else $error("stage 3 item lost while blocked");

  // the fill flag only clears on reset
  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst)
    wrapped |=> wrapped)
    else $error("wrap flag dropped");

  // a result only appears from a filled last stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s3_valid))
    else $error("result without stage 3 item");
`endif

endmodule

[test/sfd_tb_pkg.sv]
// sfd_tb_pkg: register addresses, reset values and result latency shared by
// the stereo feedback delay testbench files. Depends on sfd_pkg for widths.
package sfd_tb_pkg;

  localparam logic [sfd_pkg::PADDR_W-1:0] GAIN_ADDR  = 'd0;
  localparam logic [sfd_pkg::PADDR_W-1:0] DELAY_ADDR = 'd4;

  localparam logic [15:0] GAIN_AT_RESET  = 16'd29491;
  localparam logic [14:0] DELAY_AT_RESET = 15'd24000;

  localparam int RESULT_LATENCY = 4;

endpackage

[test/sfd_echo_checker.sv]
// sfd_echo_checker: watches the sample, result and register ports of the
// stereo feedback delay, predicts each echo mix and compares it on arrival.
// Depends on sfd_pkg and sfd_tb_pkg.
module sfd_echo_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [15:0]          left_sample,
  input  logic signed [15:0]          right_sample,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [16:0]          left_result,
  input  logic signed [16:0]          right_result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [sfd_pkg::PADDR_W-1:0] paddr,
  input  logic [sfd_pkg::PDATA_W-1:0] pwdata,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH = 32768;

  // tanh(k/8) in Q1.15, k = 0..16
  localparam int TANH_Q15 [17] = '{
    0, 4075, 8025, 11743, 15143, 18173, 20813, 23071, 24956,
    26519, 27797, 28832, 29660, 30322, 30847, 31262, 31589
  };

  typedef struct packed {
    logic signed [16:0] left;
    logic signed [16:0] right;
  } mix_t;

  mix_t               pending_mixes [$];
  logic signed [15:0] left_line  [LINE_DEPTH];
  logic signed [15:0] right_line [LINE_DEPTH];
  logic [14:0]        wr_pos;
  logic [15:0]        gain;
  logic [14:0]        delay;

  logic [14:0]        rd_pos;
  logic signed [15:0] left_tap, right_tap;
  mix_t               mix, got;

  // Soft clip: piecewise-linear tanh over 17 knots, magnitude clamped below 2.0
  function automatic logic signed [15:0] tanh_clip(input int x);
    int mag, seg, frac, y;
    mag = (x < 0) ? -x : x;
    if (mag > 65535) mag = 65535;
    seg = mag >> 12;
    if (seg > 15) seg = 15;
    frac = mag - (seg << 12);
    y = TANH_Q15[seg] + (((TANH_Q15[seg+1] - TANH_Q15[seg]) * frac + 2048) >> 12);
    return 16'((x < 0) ? -y : y);
  endfunction

  // delayed * gain in Q0.16, rounded to nearest with ties up
  function automatic int feedback_term(input logic signed [15:0] v, input logic [15:0] g);
    return int'((longint'(v) * longint'(g) + 64'sd32768) >>> 16);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wr_pos     = '0;
      gain       = sfd_tb_pkg::GAIN_AT_RESET;
      delay      = sfd_tb_pkg::DELAY_AT_RESET;
      mismatches = 0;
      pending_mixes.delete();
      foreach (left_line[i]) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          sfd_tb_pkg::GAIN_ADDR:  gain  = pwdata[15:0];
          sfd_tb_pkg::DELAY_ADDR: delay = pwdata[14:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        // store depth is 2^15, so the 15-bit difference wraps for free
        rd_pos    = wr_pos - delay;
        left_tap  = left_line[rd_pos];
        right_tap = right_line[rd_pos];
        left_line[wr_pos]  = tanh_clip(int'(left_sample) + feedback_term(left_tap, gain));
        right_line[wr_pos] = tanh_clip(int'(right_sample) + feedback_term(right_tap, gain));
        mix.left  = 17'(int'(left_sample) + (int'(left_tap) >>> 1));
        mix.right = 17'(int'(right_sample) + (int'(right_tap) >>> 1));
        pending_mixes.push_back(mix);
        wr_pos = wr_pos + 15'd1;
      end

      if (out_valid && !out_stall) begin
        got.left  = left_result;
        got.right = right_result;
        if (pending_mixes.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item pending, got left %0d right %0d",
                   $time, got.left, got.right);
        end else begin
          mix = pending_mixes.pop_front();
          if (got.left !== mix.left) begin
            mismatches++;
            $display("%0t: left_result expected %0d, got %0d",
                     $time, mix.left, got.left);
          end
          if (got.right !== mix.right) begin
            mismatches++;
            $display("%0t: right_result expected %0d, got %0d",
                     $time, mix.right, got.right);
          end
        end
      end
    end
    outstanding = pending_mixes.size();
  end

endmodule

[test/tb_top.sv]
// tb_top: clock, reset, sample and register stimulus for the stereo feedback
// delay, with the verdict. Depends on sfd_pkg, sfd_tb_pkg, sfd_echo_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [15:0]          left_sample = '0;
  logic signed [15:0]          right_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [16:0]          left_result, right_result;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [sfd_pkg::PADDR_W-1:0] paddr = '0;
  logic [sfd_pkg::PDATA_W-1:0] pwdata = '0;
  logic [sfd_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  int    mismatches, outstanding;
  int    burst_left = 0;
  bit    steady = 1'b0;
  flow_t flow = FLOW_FREE;
  int    flow_left = 0;
  int    tick = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stereo_feedback_delay_softclip dut (
    .clk, .rst, .in_valid, .in_stall, .left_sample, .right_sample,
    .out_valid, .out_stall, .left_result, .right_result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sfd_echo_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .left_sample, .right_sample,
    .out_valid, .out_stall, .left_result, .right_result,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .outstanding
  );

  // result-side backpressure in randomly chosen modes
  always @(posedge clk) begin
    tick++;
    if (flow_left == 0) begin
      flow      = flow_t'($urandom_range(0, 3));
      flow_left = $urandom_range(32, 256);
    end
    flow_left--;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (flow)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
        FLOW_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
        default:    out_stall <= ((tick % 7) < 3);
      endcase
    end
  end

  function automatic logic signed [15:0] pick_sample();
    int mag;
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'(int'($urandom_range(0, 512)) - 256);
      3, 4: begin
        mag = $urandom_range(24576, 32767);
        return $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
      end
      default: return 16'($urandom());
    endcase
  endfunction

  // Returns in the step of acceptance unless a gap follows.
  task automatic push_frame(input logic signed [15:0] l, input logic signed [15:0] r);
    int gap;
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off input until every predicted mix has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (sfd_tb_pkg::RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic reg_write(input logic [sfd_pkg::PADDR_W-1:0] addr,
                           input logic [sfd_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Junk in the unused upper bits must be ignored by the block.
  task automatic set_echo(input logic [15:0] g, input logic [14:0] d);
    reg_write(sfd_tb_pkg::GAIN_ADDR, ($urandom() & 32'hFFFF_0000) | 32'(g));
    reg_write(sfd_tb_pkg::DELAY_ADDR, ($urandom() & 32'hFFFF_8000) | 32'(d));
  endtask

  initial begin
    int          n_items, settle_at;
    logic [15:0] g;
    logic [14:0] d;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: long delay, so the echo taps read the cleared store
    push_frame(16'sd0, 16'sd0);
    push_frame(16'sh7FFF, 16'sh8000);
    push_frame(16'sh8000, 16'sh7FFF);
    push_frame(-16'sd1, 16'sd1);
    push_frame(16'sd1, -16'sd1);
    settle();

    // gain past 0.9 and a one-sample delay: full-scale runs drive the clip hard
    reg_write(sfd_tb_pkg::GAIN_ADDR, 32'hFFFF_FFFF);
    reg_write(sfd_tb_pkg::DELAY_ADDR, 32'hFFFF_0001);
    repeat (4) push_frame(16'sh7FFF, 16'sh7FFF);
    repeat (4) push_frame(16'sh8000, 16'sh8000);
    repeat (2) begin
      push_frame(16'sh7FFF, 16'sh8000);
      push_frame(16'sh8000, 16'sh7FFF);
    end
    settle();

    // zero delay: the tap is the entry about to be overwritten
    reg_write(sfd_tb_pkg::DELAY_ADDR, 32'h0000_8000);
    push_frame(16'sh7FFF, 16'sh8000);
    push_frame(16'sh8000, 16'sh7FFF);
    push_frame(16'sd0, -16'sd1);
    push_frame(-16'sd1, 16'sd0);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin g = 16'd58982; d = 15'd3; end
        1: begin g = 16'd0; d = 15'd2; end
        2: begin g = 16'd29491; d = 15'd1; end
        3: begin g = 16'hFFFF; d = 15'($urandom_range(4, 64)); end
        4: begin g = 16'($urandom_range(0, 58982)); d = 15'h7FFF; end
        5: begin g = 16'd1; d = 15'd0; end
        6: begin g = 16'($urandom_range(0, 58982)); d = 15'($urandom_range(1, 200)); end
        default: begin g = 16'd58982; d = 15'($urandom_range(1, 16)); end
      endcase
      set_echo(g, d);
      steady    = ($urandom_range(0, 3) == 0);
      n_items   = $urandom_range(95, 115);
      settle_at = $urandom_range(0, 1) ? $urandom_range(10, n_items - 10) : -1;
      for (int i = 0; i < n_items; i++) begin
        push_frame(pick_sample(), pick_sample());
        if (i == settle_at) settle();
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
